### rtl/core/ecs_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ecs_pkg
// Shared types and defaults for the obstacle clearance scan block.
// ----------------------------------------------------------------------------
package ecs_pkg;

  localparam int DEF_MAX_BOXES  = 64;
  localparam int DEF_COORD_BITS = 24;

  typedef enum logic [1:0] {
    CMD_CLEAR = 2'd0,
    CMD_ADD   = 2'd1,
    CMD_QUERY = 2'd2
  } cmd_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_RESULT
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic accept;
    logic rd_en;
    logic finish;
  } ctrl_t;

  // datapath to controller
  typedef struct packed {
    logic is_query;
    logic cnt_zero;
    logic idx_last;
    logic out_free;
  } stat_t;

endpackage

### rtl/core/ecs_in_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ecs_in_if
// Item channel: command, edge endpoints, box sides and starting limits.
// ----------------------------------------------------------------------------
interface ecs_in_if #(
  parameter int COORD_BITS = ecs_pkg::DEF_COORD_BITS
);
  logic                         valid;
  logic                         ready;
  logic [1:0]                   cmd;
  logic signed [COORD_BITS-1:0] start_x;
  logic signed [COORD_BITS-1:0] start_y;
  logic signed [COORD_BITS-1:0] end_x;
  logic signed [COORD_BITS-1:0] end_y;
  logic signed [COORD_BITS-1:0] box_left;
  logic signed [COORD_BITS-1:0] box_top;
  logic signed [COORD_BITS-1:0] box_right;
  logic signed [COORD_BITS-1:0] box_bottom;
  logic signed [COORD_BITS-1:0] low_limit_in;
  logic signed [COORD_BITS-1:0] high_limit_in;

  modport source (
    output valid, cmd, start_x, start_y, end_x, end_y,
           box_left, box_top, box_right, box_bottom, low_limit_in, high_limit_in,
    input  ready
  );

  modport sink (
    input  valid, cmd, start_x, start_y, end_x, end_y,
           box_left, box_top, box_right, box_bottom, low_limit_in, high_limit_in,
    output ready
  );
endinterface

### rtl/core/ecs_out_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ecs_out_if
// Result channel: narrowed limits, full flag and box count.
// ----------------------------------------------------------------------------
interface ecs_out_if #(
  parameter int COORD_BITS = ecs_pkg::DEF_COORD_BITS,
  parameter int CNT_W      = $clog2(ecs_pkg::DEF_MAX_BOXES + 1)
);
  logic                         valid;
  logic                         ready;
  logic signed [COORD_BITS-1:0] low_limit;
  logic signed [COORD_BITS-1:0] high_limit;
  logic                         store_full;
  logic [CNT_W-1:0]             box_count;

  modport source (
    output valid, low_limit, high_limit, store_full, box_count,
    input  ready
  );

  modport sink (
    input  valid, low_limit, high_limit, store_full, box_count,
    output ready
  );
endinterface

### rtl/core/ecs_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ecs_ctrl
// Sequencer: takes one transaction, steps the box scan, hands off the result.
// ----------------------------------------------------------------------------
module ecs_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  ecs_pkg::stat_t  stat,
  output ecs_pkg::ctrl_t  ctrl
);

  ecs_pkg::state_t state;
  ecs_pkg::state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ecs_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next  = state;
    in_ready    = 1'b0;
    ctrl.accept = 1'b0;
    ctrl.rd_en  = 1'b0;
    ctrl.finish = 1'b0;
    unique case (state)
      ecs_pkg::ST_IDLE: begin
        // nothing is taken while reset is held
        in_ready = !rst;
        if (in_valid && !rst) begin
          ctrl.accept = 1'b1;
          if (stat.is_query && !stat.cnt_zero) begin
            state_next = ecs_pkg::ST_SCAN;
          end else begin
            state_next = ecs_pkg::ST_RESULT;
          end
        end
      end
      ecs_pkg::ST_SCAN: begin
        ctrl.rd_en = 1'b1;
        if (stat.idx_last) begin
          state_next = ecs_pkg::ST_DRAIN;
        end
      end
      // last read data is folded in during this cycle
      ecs_pkg::ST_DRAIN: begin
        state_next = ecs_pkg::ST_RESULT;
      end
      ecs_pkg::ST_RESULT: begin
        if (stat.out_free) begin
          ctrl.finish = 1'b1;
          state_next  = ecs_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = ecs_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

### rtl/core/ecs_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ecs_dp
// Datapath: box memory, edge registers, limit narrowing and result register.
// ----------------------------------------------------------------------------
module ecs_dp #(
  parameter int MAX_BOXES  = ecs_pkg::DEF_MAX_BOXES,
  parameter int COORD_BITS = ecs_pkg::DEF_COORD_BITS
) (
  input  logic           clk,
  input  logic           rst,
  ecs_in_if.sink         item,
  ecs_out_if.source      result,
  input  ecs_pkg::ctrl_t ctrl,
  output ecs_pkg::stat_t stat
);

  localparam int CW    = COORD_BITS;
  localparam int CNT_W = $clog2(MAX_BOXES + 1);
  localparam int IDX_W = (MAX_BOXES > 1) ? $clog2(MAX_BOXES) : 1;
  localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_BOXES);
  localparam logic signed [CW-1:0] COORD_MIN = {1'b1, {(CW-1){1'b0}}};

  logic [4*CW-1:0] mem [MAX_BOXES];
  logic [4*CW-1:0] rdata;
  logic            rd_valid;

  logic [CNT_W-1:0] count;
  logic [IDX_W-1:0] idx;
  logic             is_q;
  logic             full;
  logic             horiz;
  logic signed [CW-1:0] span_a;
  logic signed [CW-1:0] span_z;
  logic signed [CW-1:0] line;
  logic signed [CW-1:0] lo;
  logic signed [CW-1:0] hi;

  logic                 is_add;
  logic                 at_max;
  logic                 in_horiz;
  logic signed [CW-1:0] in_a;
  logic signed [CW-1:0] in_z;

  logic signed [CW-1:0] b_left, b_top, b_right, b_bottom;
  logic signed [CW-1:0] sp_lo, sp_hi, sd_lo, sd_hi;
  logic                 overlap;
  logic                 out_free;

  assign is_add   = (item.cmd == ecs_pkg::CMD_ADD);
  assign at_max   = (count == CNT_MAX);
  assign in_horiz = (item.start_y == item.end_y);
  assign out_free = !result.valid || result.ready;

  // order the endpoints along the edge
  always_comb begin
    logic signed [CW-1:0] p;
    logic signed [CW-1:0] q;
    p = in_horiz ? item.start_x : item.start_y;
    q = in_horiz ? item.end_x   : item.end_y;
    if (p > q) begin
      in_a = q;
      in_z = p;
    end else begin
      in_a = p;
      in_z = q;
    end
  end

  assign stat.is_query = (item.cmd == ecs_pkg::CMD_QUERY);
  assign stat.cnt_zero = (count == '0);
  assign stat.idx_last = (CNT_W'(idx) == count - CNT_W'(1));
  assign stat.out_free = out_free;

  // box memory, registered read
  always_ff @(posedge clk) begin
    if (ctrl.accept && is_add && !at_max) begin
      mem[count[IDX_W-1:0]] <= {item.box_bottom, item.box_right, item.box_top, item.box_left};
    end
    rdata <= mem[idx];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count    <= '0;
      rd_valid <= 1'b0;
    end else begin
      rd_valid <= ctrl.rd_en;
      if (ctrl.accept) begin
        if (item.cmd == ecs_pkg::CMD_CLEAR) begin
          count <= '0;
        end else if (is_add && !at_max) begin
          count <= count + CNT_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.accept) begin
      idx <= '0;
    end else if (ctrl.rd_en) begin
      idx <= idx + IDX_W'(1);
    end
  end

  assign b_left   = rdata[CW-1:0];
  assign b_top    = rdata[2*CW-1:CW];
  assign b_right  = rdata[3*CW-1:2*CW];
  assign b_bottom = rdata[4*CW-1:3*CW];

  assign sp_lo   = horiz ? b_left   : b_top;
  assign sp_hi   = horiz ? b_right  : b_bottom;
  assign sd_lo   = horiz ? b_top    : b_left;
  assign sd_hi   = horiz ? b_bottom : b_right;
  assign overlap = (span_a < sp_hi) && (sp_lo <= span_z);

  always_ff @(posedge clk) begin
    if (ctrl.accept) begin
      is_q   <= stat.is_query;
      full   <= is_add && at_max;
      horiz  <= in_horiz;
      span_a <= in_a;
      span_z <= in_z;
      line   <= in_horiz ? item.start_y : item.start_x;
      lo     <= item.low_limit_in;
      hi     <= item.high_limit_in;
    end else if (rd_valid && overlap) begin
      if (sd_hi <= line && sd_hi > lo) begin
        lo <= sd_hi;
      end
      if (sd_lo > line && sd_lo < hi) begin
        hi <= sd_lo;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
    end else if (ctrl.finish) begin
      result.valid <= 1'b1;
    end else if (result.ready) begin
      result.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.finish) begin
      result.low_limit  <= is_q ? lo : '0;
      result.high_limit <= !is_q ? '0 : ((hi != COORD_MIN) ? hi - CW'(1) : hi);
      result.store_full <= full;
      result.box_count  <= count;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_MAX)
    else $error("box count beyond store depth");

  a_read_in_range: assert property (@(posedge clk) disable iff (rst)
    ctrl.rd_en |-> (CNT_W'(idx) < count))
    else $error("scan read beyond held boxes");

  a_full_at_max: assert property (@(posedge clk) disable iff (rst)
    (result.valid && result.store_full) |-> (result.box_count == CNT_MAX))
    else $error("store_full flagged with room left");

  a_finish_free: assert property (@(posedge clk) disable iff (rst)
    ctrl.finish |-> out_free)
    else $error("result register overwritten while pending");

  a_drain_after_scan: assert property (@(posedge clk) disable iff (rst)
    (ctrl.rd_en && stat.idx_last) |=> (rd_valid && !ctrl.rd_en))
    else $error("scan did not stop after last box");

endmodule

### rtl/core/edge_obstacle_clearance_scan.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// edge_obstacle_clearance_scan
// Obstacle box store with clearance queries for axis-parallel edges.
// ----------------------------------------------------------------------------
// Usage:
//   item   : valid/ready channel carrying one command per transaction
//            (clear, add box, query edge) with its coordinates and limits.
//   result : valid/ready channel, exactly one transaction per item.
// A clear or add, or a query with no boxes held, goes straight to the
// result state, which loads the output register once it is free. A query
// reads the box memory one entry per cycle, folds the last read in during
// the drain state, then loads the result; the scan over the single memory
// read port dominates a query. A new item is taken after the result loads.
// The result sits in an output register: if the receiver stalls, the block
// still takes one more item and holds its result until the register frees.
// Reset empties the store (count zero) and drops any pending result; the
// box memory itself is not cleared, only entries below the count are read.
// ----------------------------------------------------------------------------
module edge_obstacle_clearance_scan #(
  parameter int MAX_BOXES  = ecs_pkg::DEF_MAX_BOXES,
  parameter int COORD_BITS = ecs_pkg::DEF_COORD_BITS
) (
  input  logic      clk,
  input  logic      rst,
  ecs_in_if.sink    item,
  ecs_out_if.source result
);

  ecs_pkg::ctrl_t ctrl;
  ecs_pkg::stat_t stat;
  logic           in_ready;

  assign item.ready = in_ready;

  ecs_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (item.valid),
    .in_ready (in_ready),
    .stat     (stat),
    .ctrl     (ctrl)
  );

  ecs_dp #(
    .MAX_BOXES  (MAX_BOXES),
    .COORD_BITS (COORD_BITS)
  ) u_dp (
    .clk    (clk),
    .rst    (rst),
    .item   (item),
    .result (result),
    .ctrl   (ctrl),
    .stat   (stat)
  );

endmodule

### verif/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the obstacle clearance scan block. A predictor in
// the bench keeps its own copy of the box store and works out the limits,
// full flag and count for every accepted item. Each result transaction is
// checked against the oldest prediction. Directed tests cover the empty
// store, edge ordering, touching sides, saturation and a full store. Random
// clear / add / query sequences follow under bursty input and receiver stalls.
// ----------------------------------------------------------------------------
module tb;

  localparam int COORD_BITS   = ecs_pkg::DEF_COORD_BITS;
  localparam int MAX_BOXES    = ecs_pkg::DEF_MAX_BOXES;
  localparam int CNT_W        = $clog2(MAX_BOXES + 1);
  localparam int RANDOM_ITEMS = 560;
  localparam int DRAIN_CYCLES = 80;
  localparam int MAX_REPORTS  = 10;

  // code the package leaves unnamed
  localparam logic [1:0] CMD_UNUSED = 2'd3;

  typedef logic signed [COORD_BITS-1:0] coord_t;

  localparam coord_t COORD_MIN = {1'b1, {(COORD_BITS-1){1'b0}}};
  localparam coord_t COORD_MAX = {1'b0, {(COORD_BITS-1){1'b1}}};

  typedef struct {
    logic [1:0] cmd;
    coord_t     start_x, start_y, end_x, end_y;
    coord_t     box_left, box_top, box_right, box_bottom;
    coord_t     low_in, high_in;
  } item_t;

  typedef struct {
    coord_t left, top, right, bottom;
  } box_t;

  typedef struct {
    coord_t           low;
    coord_t           high;
    logic             full;
    logic [CNT_W-1:0] count;
  } clearance_t;

  logic clk;
  logic rst;

  ecs_in_if  #(.COORD_BITS(COORD_BITS))                item_ch ();
  ecs_out_if #(.COORD_BITS(COORD_BITS), .CNT_W(CNT_W)) result_ch ();

  edge_obstacle_clearance_scan #(
    .MAX_BOXES (MAX_BOXES),
    .COORD_BITS(COORD_BITS)
  ) u_top (
    .clk   (clk),
    .rst   (rst),
    .item  (item_ch),
    .result(result_ch)
  );

  // predictor state
  box_t        box_store [MAX_BOXES];
  int unsigned boxes_held = 0;

  clearance_t expected_clearance_q [$];
  int         mismatches = 0;
  int         burst_left = 0;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #10_000_000;
    $display("*** FAILED ***");
    $finish;
  end

  // --------------------------------------------------------------------------
  // predictor
  // --------------------------------------------------------------------------
  function automatic clearance_t predict_clearance(input item_t it);
    clearance_t r;
    coord_t     a, z, line, t, lo, hi;
    coord_t     span_lo, span_hi, side_lo, side_hi;
    logic       horiz;
    r.low  = '0;
    r.high = '0;
    r.full = 1'b0;
    case (it.cmd)
      ecs_pkg::CMD_CLEAR: begin
        boxes_held = 0;
      end
      ecs_pkg::CMD_ADD: begin
        if (boxes_held >= MAX_BOXES) begin
          r.full = 1'b1;
        end else begin
          box_store[boxes_held] = '{it.box_left, it.box_top, it.box_right, it.box_bottom};
          boxes_held++;
        end
      end
      ecs_pkg::CMD_QUERY: begin
        horiz = (it.start_y == it.end_y);
        if (horiz) begin
          a = it.start_x; z = it.end_x; line = it.start_y;
        end else begin
          // vertical edge: end_x plays no part
          a = it.start_y; z = it.end_y; line = it.start_x;
        end
        if (a > z) begin
          t = a; a = z; z = t;
        end
        lo = it.low_in;
        hi = it.high_in;
        for (int i = 0; i < boxes_held; i++) begin
          span_lo = horiz ? box_store[i].left   : box_store[i].top;
          span_hi = horiz ? box_store[i].right  : box_store[i].bottom;
          side_lo = horiz ? box_store[i].top    : box_store[i].left;
          side_hi = horiz ? box_store[i].bottom : box_store[i].right;
          if (a < span_hi && span_lo <= z) begin
            if (side_hi <= line && side_hi > lo) lo = side_hi;
            if (side_lo > line && side_lo < hi) hi = side_lo;
          end
        end
        // upper limit saturates at the bottom of the range
        if (hi > COORD_MIN) hi = hi - 1'b1;
        r.low  = lo;
        r.high = hi;
      end
      default: ;
    endcase
    r.count = CNT_W'(boxes_held);
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // item builders
  // --------------------------------------------------------------------------
  function automatic coord_t rand_coord();
    case ($urandom_range(0, 9))
      0, 1: return coord_t'($urandom);
      2: begin
        case ($urandom_range(0, 4))
          0: return COORD_MIN;
          1: return COORD_MAX;
          2: return COORD_MIN + 1'b1;
          3: return COORD_MAX - 1'b1;
          default: return '0;
        endcase
      end
      default: return coord_t'(int'($urandom_range(0, 240)) - 120);
    endcase
  endfunction

  // fields the command does not use carry random noise
  function automatic item_t noise_item(input logic [1:0] c);
    item_t it;
    it.cmd        = c;
    it.start_x    = coord_t'($urandom);
    it.start_y    = coord_t'($urandom);
    it.end_x      = coord_t'($urandom);
    it.end_y      = coord_t'($urandom);
    it.box_left   = coord_t'($urandom);
    it.box_top    = coord_t'($urandom);
    it.box_right  = coord_t'($urandom);
    it.box_bottom = coord_t'($urandom);
    it.low_in     = coord_t'($urandom);
    it.high_in    = coord_t'($urandom);
    return it;
  endfunction

  function automatic item_t mk_add(input coord_t l, input coord_t t,
                                   input coord_t r, input coord_t b);
    item_t it;
    it            = noise_item(ecs_pkg::CMD_ADD);
    it.box_left   = l;
    it.box_top    = t;
    it.box_right  = r;
    it.box_bottom = b;
    return it;
  endfunction

  function automatic item_t mk_query(input coord_t sx, input coord_t sy,
                                     input coord_t ex, input coord_t ey,
                                     input coord_t lo, input coord_t hi);
    item_t it;
    it         = noise_item(ecs_pkg::CMD_QUERY);
    it.start_x = sx;
    it.start_y = sy;
    it.end_x   = ex;
    it.end_y   = ey;
    it.low_in  = lo;
    it.high_in = hi;
    return it;
  endfunction

  function automatic item_t rand_add();
    coord_t l, t;
    if ($urandom_range(0, 9) == 0)
      return mk_add(rand_coord(), rand_coord(), rand_coord(), rand_coord());
    l = rand_coord();
    t = rand_coord();
    return mk_add(l, t, l + coord_t'($urandom_range(1, 40)),
                  t + coord_t'($urandom_range(1, 40)));
  endfunction

  function automatic item_t rand_query();
    coord_t sx, sy, ex, ey, lo, hi;
    sx = rand_coord();
    sy = rand_coord();
    ex = rand_coord();
    ey = ($urandom_range(0, 1) == 0) ? sy : rand_coord();
    lo = ($urandom_range(0, 4) < 2) ? COORD_MIN : rand_coord();
    case ($urandom_range(0, 19))
      0:                       hi = COORD_MIN;
      1, 2, 3, 4, 5, 6, 7, 8:  hi = COORD_MAX;
      default:                 hi = rand_coord();
    endcase
    return mk_query(sx, sy, ex, ey, lo, hi);
  endfunction

  // --------------------------------------------------------------------------
  // item driver: bursts of random length with random gaps
  // --------------------------------------------------------------------------
  task automatic send_item(input item_t it);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 90) : $urandom_range(1, 12);
      item_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
      burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(30, 80)
                                                 : $urandom_range(1, 12);
    end
    burst_left--;
    item_ch.valid         <= 1'b1;
    item_ch.cmd           <= it.cmd;
    item_ch.start_x       <= it.start_x;
    item_ch.start_y       <= it.start_y;
    item_ch.end_x         <= it.end_x;
    item_ch.end_y         <= it.end_y;
    item_ch.box_left      <= it.box_left;
    item_ch.box_top       <= it.box_top;
    item_ch.box_right     <= it.box_right;
    item_ch.box_bottom    <= it.box_bottom;
    item_ch.low_limit_in  <= it.low_in;
    item_ch.high_limit_in <= it.high_in;
    @(posedge clk);
    while (item_ch.ready !== 1'b1) @(posedge clk);
    expected_clearance_q.insert(expected_clearance_q.size(), predict_clearance(it));
  endtask

  // hold off until every result is back
  task automatic wait_drained();
    item_ch.valid <= 1'b0;
    @(posedge clk);
    while (expected_clearance_q.size() != 0) @(posedge clk);
  endtask

  // --------------------------------------------------------------------------
  // receiver: stall pattern draws a new mode every run
  // --------------------------------------------------------------------------
  initial begin : result_sink
    int mode;
    int run;
    result_ch.ready <= 1'b0;
    forever begin
      mode = $urandom_range(0, 3);
      run  = $urandom_range(10, 200);
      repeat (run) begin
        @(posedge clk);
        case (mode)
          0:       result_ch.ready <= 1'b1;
          1:       result_ch.ready <= ($urandom_range(0, 1) == 1);
          2:       result_ch.ready <= ($urandom_range(0, 7) != 0);
          default: result_ch.ready <= ($urandom_range(0, 5) == 0);
        endcase
      end
    end
  end

  always @(posedge clk) begin : result_check
    clearance_t want;
    if (!rst && result_ch.valid === 1'b1 && result_ch.ready === 1'b1) begin
      if (expected_clearance_q.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("%0t: result transaction with nothing expected", $realtime);
      end else begin
        want = expected_clearance_q.pop_front();
        if (result_ch.low_limit !== want.low || result_ch.high_limit !== want.high ||
            result_ch.store_full !== want.full || result_ch.box_count !== want.count) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display("%0t: mismatch low %0d/%0d high %0d/%0d full %0b/%0b count %0d/%0d",
                     $realtime, result_ch.low_limit, want.low, result_ch.high_limit,
                     want.high, result_ch.store_full, want.full, result_ch.box_count,
                     want.count);
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // tests
  // --------------------------------------------------------------------------
  task automatic test_empty_store();
    send_item(mk_query(0, 0, 10, 0, -100, 100));
    // upper limit already at the minimum must not wrap
    send_item(mk_query(3, -7, 3, 9, COORD_MAX, COORD_MIN));
    send_item(noise_item(CMD_UNUSED));
  endtask

  task automatic test_narrowing();
    send_item(mk_add(0, -20, 10, -5));
    send_item(mk_add(5, 3, 15, 9));
    send_item(mk_add(-30, -8, -20, 4));
    send_item(mk_add(20, -4, 30, 6));
    // endpoints given in reverse order
    send_item(mk_query(12, 0, -1, 0, COORD_MIN, COORD_MAX));
    // box bottom sitting exactly on the edge line
    send_item(mk_query(-40, -5, 40, -5, COORD_MIN, COORD_MAX));
    // vertical edge, end_x far away and ignored
    send_item(mk_query(0, 10, 999, -10, COORD_MIN, COORD_MAX));
    send_item(mk_query(20, -30, 20, 30, -50, 50));
    // span starts at a box's exclusive right side
    send_item(mk_query(10, 0, 12, 0, COORD_MIN, COORD_MAX));
    send_item(noise_item(CMD_UNUSED));
  endtask

  task automatic test_extremes();
    send_item(mk_add(COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX));
    send_item(mk_query(COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX, COORD_MIN, COORD_MAX));
    send_item(mk_query(COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN, COORD_MAX, COORD_MIN));
    // inverted box
    send_item(mk_add(10, 10, -10, -10));
    send_item(mk_query(-5, 0, 5, 0, COORD_MIN, COORD_MAX));
    send_item(noise_item(ecs_pkg::CMD_CLEAR));
    send_item(mk_query(-5, 0, 5, 0, COORD_MIN, COORD_MAX));
    send_item(mk_add(-3, 4, 3, 8));
    send_item(mk_query(0, 0, 1, 0, COORD_MIN, COORD_MAX));
  endtask

  task automatic test_store_full();
    send_item(noise_item(ecs_pkg::CMD_CLEAR));
    repeat (MAX_BOXES) send_item(rand_add());
    // these two are dropped and flagged
    send_item(rand_add());
    send_item(rand_add());
    send_item(mk_query(0, 0, 60, 0, COORD_MIN, COORD_MAX));
    send_item(mk_query(0, -60, 0, 60, COORD_MIN, COORD_MAX));
    send_item(noise_item(ecs_pkg::CMD_CLEAR));
    send_item(rand_add());
  endtask

  task automatic test_random_mix();
    int done;
    int n_add;
    int n_query;
    done = 0;
    while (done < RANDOM_ITEMS) begin
      if ($urandom_range(0, 2) != 0) begin
        send_item(noise_item(ecs_pkg::CMD_CLEAR));
        done++;
      end
      case ($urandom_range(0, 11))
        0:       n_add = $urandom_range(60, 70);
        1, 2:    n_add = $urandom_range(13, 40);
        default: n_add = $urandom_range(0, 12);
      endcase
      repeat (n_add) begin
        send_item(rand_add());
        done++;
      end
      n_query = $urandom_range(1, 8);
      repeat (n_query) begin
        if ($urandom_range(0, 15) == 0) begin
          send_item(noise_item(CMD_UNUSED));
        end else begin
          send_item(rand_query());
          done++;
        end
      end
      if ($urandom_range(0, 9) == 0) wait_drained();
    end
  endtask

  initial begin
    rst                   <= 1'b1;
    item_ch.valid         <= 1'b0;
    item_ch.cmd           <= ecs_pkg::CMD_CLEAR;
    item_ch.start_x       <= '0;
    item_ch.start_y       <= '0;
    item_ch.end_x         <= '0;
    item_ch.end_y         <= '0;
    item_ch.box_left      <= '0;
    item_ch.box_top       <= '0;
    item_ch.box_right     <= '0;
    item_ch.box_bottom    <= '0;
    item_ch.low_limit_in  <= '0;
    item_ch.high_limit_in <= '0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    test_empty_store();
    wait_drained();
    test_narrowing();
    test_extremes();
    wait_drained();
    test_store_full();
    wait_drained();
    test_random_mix();

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && expected_clearance_q.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
